FILE: hw/rtl/iiea_pkg.sv
`timescale 1ns / 1ps

package iiea_pkg;

  // fixed field widths of the command and result beats
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned STAT_W = 2;

  // default geometry of the table
  localparam int unsigned DEFAULT_DEPTH      = 16;
  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

FILE: hw/rtl/iiea_ram.sv
`timescale 1ns / 1ps

module iiea_ram #(
  parameter int unsigned Depth     = iiea_pkg::DEFAULT_DEPTH,
  parameter int unsigned DataWidth = iiea_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [DataWidth-1:0]       wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [DataWidth-1:0]       rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/indexed_insert_erase_array_core.sv
`timescale 1ns / 1ps

// Bounded ordered table of DEPTH words with a live count.
// Command channel: in_valid_i / in_stall_o carry cmd_i, position_i, value_i;
// a beat is taken when valid is high and stall is low.
// Result channel: out_valid_o / out_stall_i carry read_data_o, count_o,
// empty_res_o and status_o, one result beat per command beat.
// The block takes one command at a time and holds in_stall_o high while it
// works on it. Set writes the table, get reads it, and clear, refused or
// unknown commands go straight to the result; insert and erase first move
// entries, count - position of them for insert and count - position - 1
// for erase, then insert writes the new value. Every moved entry costs one
// read and one write of the table RAM, never in the same cycle, stepped by
// one shared increment/decrement pointer unit.
// A finished result sits in an output register; a new command is taken
// while it waits, and the next result waits until it has been taken.
// While out_stall_i is high the result beat holds its value.
// Reset clears the count and the handshake state; the table contents are
// left as they were and are only read below the count.
module indexed_insert_erase_array_core #(
  parameter int unsigned DEPTH      = iiea_pkg::DEFAULT_DEPTH,
  parameter int unsigned DATA_WIDTH = iiea_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [iiea_pkg::CMD_W-1:0]   cmd_i,
  input  logic [iiea_pkg::POS_W-1:0]   position_i,
  input  logic [iiea_pkg::VAL_W-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [iiea_pkg::VAL_W-1:0]   read_data_o,
  output logic [iiea_pkg::CNT_W-1:0]   count_o,
  output logic                         empty_res_o,
  output logic [iiea_pkg::STAT_W-1:0]  status_o
);

  import iiea_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_STORE,
    S_READ,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         lim_q, lim_d;
  logic                  down_q, down_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  get_q, get_d;
  status_e               status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  logic [VAL_W-1:0]      out_data_q, out_data_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;
  logic                  out_empty_q, out_empty_d;
  status_e               out_status_q, out_status_d;
  logic                  out_load;
  logic                  in_accept;

  // memory port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // widened views of the command fields and the count
  cmd_e                  cmd_in;
  logic [31:0]           pos_ext;
  logic [31:0]           cnt_ext;
  logic [31:0]           cnt_m1_ext;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;
  logic                  pos_lt_cnt;
  logic                  pos_le_cnt;
  logic                  tbl_full;
  logic [AW-1:0]         ptr_step;

  assign cmd_in     = cmd_e'(cmd_i);
  assign pos_ext    = 32'(position_i);
  assign cnt_ext    = 32'(count_q);
  assign cnt_m1_ext = cnt_ext - 32'd1;
  assign val_ext    = 64'(value_i);
  assign rd_ext     = 64'(ram_rdata);
  assign pos_lt_cnt = pos_ext < cnt_ext;
  assign pos_le_cnt = pos_ext <= cnt_ext;
  assign tbl_full   = cnt_ext >= 32'(DEPTH);

  // shared pointer unit: one step up or down
  assign ptr_step = down_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    lim_d        = lim_q;
    down_d       = down_q;
    pos_d        = pos_q;
    val_d        = val_q;
    get_d        = get_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr_step;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          pos_d    = pos_ext[AW-1:0];
          val_d    = val_ext[DATA_WIDTH-1:0];
          get_d    = 1'b0;
          status_d = ST_OK;
          state_d  = S_RESP;
          unique case (cmd_in)
            CMD_SET: begin
              if (pos_lt_cnt) begin
                state_d = S_STORE;
              end else begin
                status_d = ST_RANGE;
              end
            end
            CMD_GET: begin
              if (pos_lt_cnt) begin
                get_d   = 1'b1;
                state_d = S_READ;
              end else begin
                status_d = ST_RANGE;
              end
            end
            CMD_INSERT: begin
              if (!pos_le_cnt) begin
                status_d = ST_RANGE;
              end else if (tbl_full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                ptr_d   = cnt_ext[AW-1:0];
                lim_d   = pos_ext[AW-1:0];
                down_d  = 1'b1;
                state_d = (pos_ext == cnt_ext) ? S_STORE : S_SHIFT_RD;
              end
            end
            CMD_ERASE: begin
              if (pos_lt_cnt) begin
                count_d = count_q - CW'(1);
                ptr_d   = pos_ext[AW-1:0];
                lim_d   = cnt_m1_ext[AW-1:0];
                down_d  = 1'b0;
                state_d = (pos_ext == cnt_m1_ext) ? S_RESP : S_SHIFT_RD;
              end else begin
                status_d = ST_RANGE;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_step;
        state_d   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_step;
        if (ptr_step == lim_q) begin
          state_d = down_q ? S_STORE : S_RESP;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        state_d   = S_RESP;
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load     = 1'b1;
          out_valid_d  = 1'b1;
          out_data_d   = get_q ? rd_ext[VAL_W-1:0] : '0;
          out_count_d  = cnt_ext[CNT_W-1:0];
          out_empty_d  = (count_q == '0);
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, count and registered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      lim_q       <= lim_d;
      down_q      <= down_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      get_q       <= get_d;
      status_q    <= status_d;
      if (out_load) begin
        out_data_q   <= out_data_d;
        out_count_q  <= out_count_d;
        out_empty_q  <= out_empty_d;
        out_status_q <= out_status_d;
      end
    end
  end

  iiea_ram #(
    .Depth    (DEPTH),
    .DataWidth(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign count_o     = out_count_q;
  assign empty_res_o = out_empty_q;
  assign status_o    = out_status_q;

`ifndef SYNTHESIS
  // live count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("live count above table depth");

  // a taken command beat always makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("command taken but block not busy");

  // a new result beat only comes out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == S_RESP) && (!out_valid_q || !out_stall_i))
    else $error("result loaded outside response state or over a held beat");

  // the table is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table written and read in one cycle");
`endif

endmodule
